/* hdl/cpnp_pkg.sv */
// Shared constants, types and helper functions of the cpio newc entry parser.
`default_nettype none
package cpnp_pkg;

  localparam int unsigned HDR_LEN    = 110;
  localparam int unsigned NUM_FIELDS = 13;
  localparam int unsigned FLD_AW     = 4;
  localparam int unsigned F_FILESIZE = 6;
  localparam int unsigned F_NAMESIZE = 11;
  localparam int unsigned F_CHECK    = 12;
  localparam int unsigned TRAILER_NS = 11;
  localparam int unsigned DATA_ALIGN = 4;
  localparam int unsigned ALIGN_W    = $clog2(DATA_ALIGN);

  localparam logic [3:0] IDX_CHECK    = 4'd11;
  localparam logic [3:0] IDX_NAME_OFF = 4'd12;
  localparam logic [3:0] IDX_CONTENT  = 4'd13;

  localparam logic [2:0] ST_ENTRY    = 3'd0;
  localparam logic [2:0] ST_TRAILER  = 3'd1;
  localparam logic [2:0] ST_BAD_MAG  = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_UNTERM   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef struct packed {
    logic        start;
    logic [31:0] name_off;
    logic [31:0] content;
  } burst_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] status;
  } fail_t;

  typedef struct packed {
    logic busy;
  } emit_stat_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) r = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) r = c[3:0] + 4'd9;
    return r;
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd1, 3'd3: r = 8'h37;
      3'd5:       r = 8'h31;
      default:    r = 8'h30;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0:    r = 8'h54;
      4'd1:    r = 8'h52;
      4'd2:    r = 8'h41;
      4'd3:    r = 8'h49;
      4'd4:    r = 8'h4C;
      4'd5:    r = 8'h45;
      4'd6:    r = 8'h52;
      default: r = 8'h21;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/cpnp_ifs.sv */
// Channel interfaces: archive byte input, record output and size configuration.
`default_nettype none
interface cpnp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;
  modport source (output valid, output archive_byte, input ready);
  modport sink   (input valid, input archive_byte, output ready);
endinterface

interface cpnp_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  field_index;
  logic [31:0] field_value;
  logic        last_of_run;
  modport source (output valid, output status, output field_index, output field_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input status, input field_index, input field_value,
                  input last_of_run, output ready);
endinterface

interface cpnp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] archive_size;
  modport source (output valid, output archive_size, input ready);
  modport sink   (input valid, input archive_size, output ready);
endinterface
`default_nettype wire

/* hdl/cpnp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cpnp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* hdl/cpnp_parser.sv */
// Byte-level parser: header, name and skip phases, range checks, field writes.
`default_nettype none
module cpnp_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [7:0]                  byte_i,
  output logic                             ready_o,
  input  wire logic [31:0]                 size_i,
  input  wire cpnp_pkg::emit_stat_t        emit_i,
  output logic                             we_o,
  output logic [cpnp_pkg::FLD_AW-1:0]      waddr_o,
  output logic [31:0]                      wdata_o,
  output cpnp_pkg::burst_t                 burst_o,
  output cpnp_pkg::fail_t                  fail_o
);
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_NAME   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;
  localparam int unsigned AW = cpnp_pkg::ALIGN_W;

  logic [1:0]  phase_q, phase_d;
  logic [6:0]  off_q, off_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] entry_q, entry_d;
  logic        match_q, match_d;
  logic [3:0]  nidx_q, nidx_d;
  logic        halted_q, halted_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] ns_q, ns_d, fs_q, fs_d;
  logic [32:0] hdr_end_q, hdr_end_d;
  logic [33:0] cur_q;
  logic [34:0] content_q;
  logic [35:0] sum_q, next_q;
  logic [31:0] skip_q;

  logic        take, hdr_field, field_end;
  logic [6:0]  foff;
  logic [3:0]  dig;
  logic [32:0] base;
  logic [34:0] cur_rnd;
  logic [35:0] sum_rnd;
  logic        match_now;

  assign foff      = off_q - 7'd6;
  assign hdr_field = phase_q == PH_HEADER && off_q >= 7'd6 &&
                     off_q <= 7'(cpnp_pkg::HDR_LEN - 1);
  assign field_end = hdr_field && foff[2:0] == 3'd7;
  assign ready_o   = !(emit_i.busy && field_end && !halted_q);
  assign take      = valid_i && ready_o && !halted_q;
  assign dig       = cpnp_pkg::hex_digit(byte_i);
  assign base      = {1'b0, entry_q} + 33'(cpnp_pkg::HDR_LEN);
  assign acc_d     = (foff[2:0] == 3'd0) ? {28'd0, dig} : {acc_q[27:0], dig};
  assign match_now = match_q && !(nidx_q < 4'd10 && byte_i != cpnp_pkg::trailer_char(nidx_q));

  assign we_o    = take && field_end;
  assign waddr_o = foff[6:3];
  assign wdata_o = acc_d;

  assign cur_rnd = {1'b0, cur_q} + 35'(cpnp_pkg::DATA_ALIGN - 1);
  assign sum_rnd = sum_q + 36'(cpnp_pkg::DATA_ALIGN - 1);

  always_comb begin
    phase_d   = phase_q;
    off_d     = off_q;
    rem_d     = rem_q;
    entry_d   = entry_q;
    match_d   = match_q;
    nidx_d    = nidx_q;
    halted_d  = halted_q;
    ns_d      = ns_q;
    fs_d      = fs_q;
    hdr_end_d = hdr_end_q;
    burst_o   = '0;
    fail_o    = '0;
    if (take) begin
      unique case (phase_q)
        PH_HEADER: begin
          off_d = off_q + 7'd1;
          if (off_q == 7'd0) hdr_end_d = base;
          if (field_end && foff[6:3] == 4'(cpnp_pkg::F_NAMESIZE)) ns_d = acc_d;
          if (field_end && foff[6:3] == 4'(cpnp_pkg::F_FILESIZE)) fs_d = acc_d;
          if (off_q == 7'd0 && base > {1'b0, size_i}) begin
            fail_o = '{valid: 1'b1, status: cpnp_pkg::ST_INVALID};
          end else if (off_q < 7'd6 && byte_i != cpnp_pkg::magic_char(off_q[2:0])) begin
            fail_o = '{valid: 1'b1, status: cpnp_pkg::ST_BAD_MAG};
          end else if (off_q == 7'(cpnp_pkg::HDR_LEN - 1)) begin
            if (ns_q == 32'd0 || cur_q > {2'd0, size_i}) begin
              fail_o = '{valid: 1'b1, status: cpnp_pkg::ST_INVALID};
            end else begin
              phase_d = PH_NAME;
              rem_d   = ns_q;
              match_d = 1'b1;
              nidx_d  = 4'd0;
              off_d   = 7'd0;
            end
          end
        end
        PH_NAME: begin
          match_d = match_now;
          if (nidx_q < 4'd10) nidx_d = nidx_q + 4'd1;
          rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            if (byte_i != 8'd0) begin
              fail_o = '{valid: 1'b1, status: cpnp_pkg::ST_UNTERM};
            end else if (ns_q == 32'(cpnp_pkg::TRAILER_NS) && match_now) begin
              fail_o = '{valid: 1'b1, status: cpnp_pkg::ST_TRAILER};
            end else if (content_q > {3'd0, size_i}) begin
              fail_o = '{valid: 1'b1, status: cpnp_pkg::ST_OVERFLOW};
            end else if (sum_q > {4'd0, size_i} || next_q > {4'd0, size_i}) begin
              fail_o = '{valid: 1'b1, status: cpnp_pkg::ST_INVALID};
            end else begin
              burst_o = '{start: 1'b1, name_off: hdr_end_q[31:0], content: content_q[31:0]};
              entry_d = next_q[31:0];
              rem_d   = skip_q;
              phase_d = (skip_q != 32'd0) ? PH_SKIP : PH_HEADER;
            end
          end
        end
        PH_SKIP: begin
          rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) phase_d = PH_HEADER;
        end
        default: phase_d = PH_HEADER;
      endcase
      if (fail_o.valid) halted_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      off_q    <= 7'd0;
      rem_q    <= 32'd0;
      entry_q  <= 32'd0;
      match_q  <= 1'b0;
      nidx_q   <= 4'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      off_q    <= off_d;
      rem_q    <= rem_d;
      entry_q  <= entry_d;
      match_q  <= match_d;
      nidx_q   <= nidx_d;
      halted_q <= halted_d;
    end
  end

  // The end-of-entry arithmetic settles one step per header byte after namesize is known.
  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q     <= acc_d;
      ns_q      <= ns_d;
      fs_q      <= fs_d;
      hdr_end_q <= hdr_end_d;
      if (phase_q == PH_HEADER) begin
        cur_q     <= {1'b0, hdr_end_q} + {2'd0, ns_q};
        content_q <= {cur_rnd[34:AW], {AW{1'b0}}};
        sum_q     <= {1'b0, content_q} + {4'd0, fs_q};
        next_q    <= {sum_rnd[35:AW], {AW{1'b0}}};
        skip_q    <= next_q[31:0] - cur_q[31:0];
      end
    end
  end

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> !emit_i.busy) else $error("field write while burst reads the store");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !burst_o.start && !fail_o.valid) else $error("activity after halt");
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(burst_o.start && fail_o.valid)) else $error("burst and status on one byte");
endmodule
`default_nettype wire

/* hdl/cpnp_emitter.sv */
// Record emitter: reads stored fields for a 14-record burst, queues status records.
`default_nettype none
module cpnp_emitter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cpnp_pkg::burst_t            burst_i,
  input  wire cpnp_pkg::fail_t             fail_i,
  output cpnp_pkg::emit_stat_t             emit_o,
  output logic                             re_o,
  output logic [cpnp_pkg::FLD_AW-1:0]      raddr_o,
  input  wire logic [31:0]                 rdata_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [2:0]                       status_o,
  output logic [3:0]                       index_o,
  output logic [31:0]                      value_o,
  output logic                             last_o
);
  logic        brst_q, spend_q;
  logic [3:0]  cnt_q;
  logic [2:0]  scode_q;
  logic [31:0] noff_q, cont_q;
  logic        s1_v_q, s1_ram_q, s1_last_q;
  logic [2:0]  s1_st_q;
  logic [3:0]  s1_idx_q;
  logic [31:0] s1_val_q;
  logic        o_v_q, o_last_q;
  logic [2:0]  o_st_q;
  logic [3:0]  o_idx_q;
  logic [31:0] o_val_q;
  logic        free, load_ok, issue_b, issue_s;

  assign free    = !o_v_q || ready_i;
  assign load_ok = !s1_v_q || free;
  assign issue_b = brst_q && load_ok;
  assign issue_s = !brst_q && spend_q && load_ok;
  assign re_o    = issue_b && cnt_q <= cpnp_pkg::IDX_CHECK;
  assign raddr_o = (cnt_q < cpnp_pkg::IDX_CHECK) ? cnt_q : 4'(cpnp_pkg::F_CHECK);
  assign emit_o.busy = brst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brst_q  <= 1'b0;
      spend_q <= 1'b0;
      cnt_q   <= 4'd0;
      s1_v_q  <= 1'b0;
      o_v_q   <= 1'b0;
    end else begin
      if (burst_i.start) begin
        brst_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (issue_b) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == cpnp_pkg::IDX_CONTENT) brst_q <= 1'b0;
      end
      if (fail_i.valid) spend_q <= 1'b1;
      else if (issue_s) spend_q <= 1'b0;
      if (issue_b || issue_s) s1_v_q <= 1'b1;
      else if (free) s1_v_q <= 1'b0;
      if (free) o_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_i.start) begin
      noff_q <= burst_i.name_off;
      cont_q <= burst_i.content;
    end
    if (fail_i.valid) scode_q <= fail_i.status;
    if (issue_b) begin
      s1_ram_q  <= cnt_q <= cpnp_pkg::IDX_CHECK;
      s1_st_q   <= cpnp_pkg::ST_ENTRY;
      s1_idx_q  <= cnt_q;
      s1_val_q  <= (cnt_q == cpnp_pkg::IDX_NAME_OFF) ? noff_q : cont_q;
      s1_last_q <= cnt_q == cpnp_pkg::IDX_CONTENT;
    end else if (issue_s) begin
      s1_ram_q  <= 1'b0;
      s1_st_q   <= scode_q;
      s1_idx_q  <= 4'd0;
      s1_val_q  <= 32'd0;
      s1_last_q <= 1'b1;
    end
    if (free && s1_v_q) begin
      o_st_q   <= s1_st_q;
      o_idx_q  <= s1_idx_q;
      o_val_q  <= s1_ram_q ? rdata_i : s1_val_q;
      o_last_q <= s1_last_q;
    end
  end

  assign valid_o  = o_v_q;
  assign status_o = o_st_q;
  assign index_o  = o_idx_q;
  assign value_o  = o_val_q;
  assign last_o   = o_last_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_i.start |-> !brst_q) else $error("burst started while one is running");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(value_o)) else $error("record dropped");
  a_last_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == cpnp_pkg::ST_ENTRY && index_o == cpnp_pkg::IDX_CONTENT |-> last_o)
    else $error("content offset record not marked last");
endmodule
`default_nettype wire

/* hdl/cpio_newc_entry_parser.sv */
// Top level of the cpio newc entry parser.
// Usage: archive bytes enter on byte_i, one transaction per byte, in order from
// offset zero. The archive length is written on cfg_i while the block is idle;
// cfg_i.ready is always high. Records leave on rec_o. When the last byte of an
// accepted name arrives, 14 records follow: fields ino..rdevminor, check, name
// offset and content offset, the last one flagged by last_of_run. The trailer or
// an error gives a single status record and the block then drops every byte.
// Output: the first record of a burst passes the burst state, read stage and
// output register; then one record per cycle while rec_o.ready is high.
// Throughput: one byte per cycle. The 13 header fields live in a small RAM that
// the burst reads; a header byte that would write a field while a burst is
// still being read out waits (byte_i.ready low). Without back-pressure on rec_o
// this happens only when the first field of the next header ends exactly 14
// bytes after the name; every rec_o stall during the burst lengthens the wait.
// Stalls on rec_o back up through a two-stage output pipe into the burst reader.
// Reset clears the parse state, the archive size and the record pipe; the field
// RAM needs no clearing since each field is written before it is read.
`default_nettype none
module cpio_newc_entry_parser (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cpnp_byte_if.sink   byte_i,
  cpnp_cfg_if.sink    cfg_i,
  cpnp_rec_if.source  rec_o
);
  logic [31:0]                    size_q;
  logic                           we, re;
  logic [cpnp_pkg::FLD_AW-1:0]    waddr, raddr;
  logic [31:0]                    wdata, rdata;
  cpnp_pkg::burst_t               burst;
  cpnp_pkg::fail_t                fail;
  cpnp_pkg::emit_stat_t           emit;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= 32'd0;
    else if (cfg_i.valid) size_q <= cfg_i.archive_size;
  end

  cpnp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .byte_i  (byte_i.archive_byte),
    .ready_o (byte_i.ready),
    .size_i  (size_q),
    .emit_i  (emit),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .burst_o (burst),
    .fail_o  (fail)
  );

  cpnp_ram #(.WIDTH(32), .DEPTH(cpnp_pkg::NUM_FIELDS)) u_fields (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cpnp_emitter u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .burst_i  (burst),
    .fail_i   (fail),
    .emit_o   (emit),
    .re_o     (re),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .valid_o  (rec_o.valid),
    .ready_i  (rec_o.ready),
    .status_o (rec_o.status),
    .index_o  (rec_o.field_index),
    .value_o  (rec_o.field_value),
    .last_o   (rec_o.last_of_run)
  );
endmodule
`default_nettype wire
